// File: design/y2r_pkg.sv
// Package for the YUV 4:2:0 to RGB565 converter: shared types and chroma term ROMs.
// The ROMs are filled at elaboration from integer BT.601 factors. No dependencies.
`timescale 1ns / 1ps

package y2r_pkg;

    // Chroma term: truncated product of a factor and (c - 128), range -226..225
    typedef logic signed [8:0] t_term;
    typedef t_term t_term_rom [256];

    // The four terms shared by one quad
    typedef struct packed {
        t_term ub;
        t_term ug;
        t_term vg;
        t_term vr;
    } t_terms;

    typedef enum logic [1:0] {
        COEF_UB,
        COEF_UG,
        COEF_VG,
        COEF_VR
    } t_coef;

    localparam int UB_NUM = 1772;
    localparam int UB_DEN = 1000;
    localparam int UG_NUM = 34414;
    localparam int UG_DEN = 100000;
    localparam int VG_NUM = 71414;
    localparam int VG_DEN = 100000;
    localparam int VR_NUM = 1402;
    localparam int VR_DEN = 1000;

    localparam int CHROMA_OFS = 128;

    // RGB565 field masks
    localparam logic [7:0] R_MASK = 8'hF8;
    localparam logic [7:0] G_MASK = 8'hFC;

    // Builds one ROM: sign(m) * floor(|m| * N / D), truncated toward zero
    function automatic t_term_rom build_rom(t_coef sel);
        t_term_rom rom;
        int m;
        int a;
        int q;
        for (int i = 0; i < 256; i++) begin
            m = i - CHROMA_OFS;
            a = (m < 0) ? -m : m;
            unique case (sel)
                COEF_UB: q = (a * UB_NUM) / UB_DEN;
                COEF_UG: q = (a * UG_NUM) / UG_DEN;
                COEF_VG: q = (a * VG_NUM) / VG_DEN;
                COEF_VR: q = (a * VR_NUM) / VR_DEN;
                default: q = 0;
            endcase
            if (m < 0) begin
                q = -q;
            end
            rom[i] = t_term'(q);
        end
        return rom;
    endfunction

    localparam t_term_rom UB_ROM = build_rom(COEF_UB);
    localparam t_term_rom UG_ROM = build_rom(COEF_UG);
    localparam t_term_rom VG_ROM = build_rom(COEF_VG);
    localparam t_term_rom VR_ROM = build_rom(COEF_VR);

endpackage

// File: design/y2r_term_rom.sv
// Chroma term lookup: maps the U and V bytes of a quad to the four color terms.
// Depends on y2r_pkg for the constant ROMs and the t_terms struct.
`timescale 1ns / 1ps

module y2r_term_rom (
    input  logic [7:0]      i_chroma_blue,
    input  logic [7:0]      i_chroma_red,
    output y2r_pkg::t_terms o_terms
);
    import y2r_pkg::*;

    // Four constant table reads, one per term
    always_comb begin
        o_terms.ub = UB_ROM[i_chroma_blue];
        o_terms.ug = UG_ROM[i_chroma_blue];
        o_terms.vg = VG_ROM[i_chroma_red];
        o_terms.vr = VR_ROM[i_chroma_red];
    end

endmodule

// File: design/y2r_pixel.sv
// One pixel: adds the chroma terms to a luma sample, clamps to 0..255, packs RGB565.
// Depends on y2r_pkg for the t_terms struct and field masks.
`timescale 1ns / 1ps

module y2r_pixel (
    input  logic [7:0]      i_luma,
    input  y2r_pkg::t_terms i_terms,
    output logic [15:0]     o_pixel
);
    import y2r_pkg::*;

    // Sums span -226..480, 11 bits signed is enough
    logic signed [10:0] w_luma;
    logic signed [10:0] w_r_sum;
    logic signed [10:0] w_g_sum;
    logic signed [10:0] w_b_sum;
    logic [7:0]         w_r;
    logic [7:0]         w_g;
    logic [7:0]         w_b;

    function automatic logic [7:0] clamp8(logic signed [10:0] x);
        logic [7:0] res;
        if (x < 0) begin
            res = 8'd0;
        end else if (x > 11'sd255) begin
            res = 8'hFF;
        end else begin
            res = x[7:0];
        end
        return res;
    endfunction

    // Channel sums
    always_comb begin
        w_luma  = $signed({3'b000, i_luma});
        w_r_sum = w_luma + 11'(i_terms.vr);
        w_g_sum = w_luma - 11'(i_terms.ug) - 11'(i_terms.vg);
        w_b_sum = w_luma + 11'(i_terms.ub);
    end

    // Clamp and pack
    always_comb begin
        w_r     = clamp8(w_r_sum);
        w_g     = clamp8(w_g_sum);
        w_b     = clamp8(w_b_sum);
        o_pixel = {w_r & R_MASK, 8'h00} | {5'b00000, w_g & G_MASK, 3'b000}
                | {11'd0, w_b[7:3]};
    end

endmodule

// File: design/yuv420_to_rgb565_block.sv
// Top level: YUV 4:2:0 quad to two RGB565 row words.
// Pipeline: input register, then result register, from input request to output request.
// Throughput: one quad per cycle unless stalled; one table-add-clamp pass between registers.
// Reset (i_rst_n, synchronous, active low) clears both valid flags; data registers are not reset.
// Depends on y2r_pkg, y2r_term_rom and y2r_pixel.
`timescale 1ns / 1ps

module yuv420_to_rgb565_block (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
    // chroma_blue, chroma_red (8 bits each, lowest first)
    input  logic [47:0] i_s_tdata,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // top_row_word [31:0], bottom_row_word [63:32]
    output logic [63:0] o_m_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready
);
    import y2r_pkg::*;

    logic        r_s1_vld;
    logic [47:0] r_s1_data;
    logic        r_out_vld;
    logic [63:0] r_out_data;

    logic        w_out_free;
    logic        w_s1_adv;
    logic        w_in_acc;
    t_terms      w_terms;
    logic [15:0] w_pix_tl;
    logic [15:0] w_pix_tr;
    logic [15:0] w_pix_bl;
    logic [15:0] w_pix_br;

    // Handshake: result register frees when empty or taken
    assign w_out_free = !r_out_vld || i_m_tready;
    assign w_s1_adv   = r_s1_vld && w_out_free;
    assign o_s_tready = !r_s1_vld || w_out_free;
    assign w_in_acc   = i_s_tvalid && o_s_tready;

    // Chroma terms shared by the quad
    y2r_term_rom u_term_rom (
        .i_chroma_blue (r_s1_data[39:32]),
        .i_chroma_red  (r_s1_data[47:40]),
        .o_terms       (w_terms)
    );

    // Four pixel datapaths
    y2r_pixel u_pix_tl (.i_luma(r_s1_data[7:0]),   .i_terms(w_terms), .o_pixel(w_pix_tl));
    y2r_pixel u_pix_tr (.i_luma(r_s1_data[15:8]),  .i_terms(w_terms), .o_pixel(w_pix_tr));
    y2r_pixel u_pix_bl (.i_luma(r_s1_data[23:16]), .i_terms(w_terms), .o_pixel(w_pix_bl));
    y2r_pixel u_pix_br (.i_luma(r_s1_data[31:24]), .i_terms(w_terms), .o_pixel(w_pix_br));

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (o_s_tready) begin
            r_s1_vld <= i_s_tvalid;
        end
        if (w_in_acc) begin
            r_s1_data <= i_s_tdata;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= r_s1_vld;
        end
        if (w_s1_adv) begin
            r_out_data <= {w_pix_br, w_pix_bl, w_pix_tr, w_pix_tl};
        end
    end

    assign o_m_tdata  = r_out_data;
    assign o_m_tvalid = r_out_vld;

    // An accepted request always lands in the input register
    a_in_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_s1_vld)
        else $error("accepted request not held in input register");

    // A stage-1 item that moves always shows up as an output request
    a_s1_moves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s1_adv |=> r_out_vld)
        else $error("stage-1 item lost on its way to the result register");

    // A blocked stage-1 item stays put
    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_vld && !w_out_free) |=> (r_s1_vld && $stable(r_s1_data)))
        else $error("stage-1 item dropped while output stalled");

    // Input side refuses only while both registers are full and the output stalls
    a_ready_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (r_s1_vld && r_out_vld && !i_m_tready))
        else $error("input stalled without a full pipeline");

endmodule
